// ----- design/page_buffer_pool_manager_core_defines.svh -----
// Assertion macros used by the page buffer pool manager RTL.
`ifndef PAGE_BUFFER_POOL_MANAGER_CORE_DEFINES_SVH
`define PAGE_BUFFER_POOL_MANAGER_CORE_DEFINES_SVH
`ifndef SYNTHESIS
// Check that ante implies cons in the same cycle.
`define PBPM_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pbpm assertion failed");
// Check that ante implies cons in the next cycle.
`define PBPM_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pbpm assertion failed");
`else
`define PBPM_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define PBPM_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ----- design/pbpm_pkg.sv -----
// Types and codes of the page buffer pool manager.
package pbpm_pkg;

    localparam int TAG_W = 39;

    // Command codes
    localparam logic [2:0] CMD_GET     = 3'd0;
    localparam logic [2:0] CMD_UNFIX   = 3'd1;
    localparam logic [2:0] CMD_ALLOC   = 3'd2;
    localparam logic [2:0] CMD_RELEASE = 3'd3;
    localparam logic [2:0] CMD_MARK    = 3'd4;

    // Status codes
    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_FIXED   = 3'd1;
    localparam logic [2:0] ST_NOBUF   = 3'd2;
    localparam logic [2:0] ST_NOTIN   = 3'd3;
    localparam logic [2:0] ST_UNFIXED = 3'd4;
    localparam logic [2:0] ST_ALREADY = 3'd5;

    // Configuration register indexes
    localparam logic [1:0] CFG_REPLACE_MODE = 2'd0;
    localparam logic [1:0] CFG_FRAME_LIMIT  = 2'd1;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [7:0]  file_id;
        logic [30:0] page_num;
        logic        mark_dirty;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  status;
        logic [3:0]  frame;
        logic        fetch;
        logic        writeback;
        logic [7:0]  wb_file;
        logic [30:0] wb_page;
        logic        last;
        logic [31:0] logical_reads;
        logic [31:0] physical_reads;
        logic [31:0] logical_writes;
        logic [31:0] physical_writes;
    } t_out_item;

    typedef struct packed {
        logic [7:0]  file_id;
        logic [30:0] page_num;
    } t_tag;

endpackage

// ----- design/pbpm_ram.sv -----
// Generic single write port RAM with registered read.
module pbpm_ram
    import pbpm_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write and read the array
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- design/page_buffer_pool_manager_core.sv -----
// Page buffer pool manager: sequencer, frame state and a shared scan compare unit.
// A lookup scans the tag RAM; a miss with no free or fresh frame runs a second scan for a victim,
// and a release rescans the tag RAM after each frame that it frees.
// Items are handled one at a time; the scan reads the tag RAM one entry per cycle.
// Reset (i_rst_n low, synchronous) clears valid, fixed and dirty bits, counters, free stack
// depth and resets config; tag and stack RAMs are not cleared and need no clearing pass.
`include "page_buffer_pool_manager_core_defines.svh"
module page_buffer_pool_manager_core
    import pbpm_pkg::*;
#(
    parameter int FRAMES = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  t_in_item   i_in_item,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output t_out_item  o_out_item,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [1:0] i_cfg_index,
    input  logic [4:0] i_cfg_data
);

    localparam int IW = $clog2(FRAMES);
    localparam int CW = $clog2(FRAMES + 1);
    localparam int LW = (CW > 5) ? CW : 5;
    localparam logic [IW-1:0] LAST_IDX = IW'(FRAMES - 1);

    typedef enum logic [3:0] {
        S_IDLE, S_SCAN, S_DEC, S_POPD, S_VDEC, S_FILL, S_RDEC, S_EMIT
    } t_state;

    typedef enum logic [1:0] {SC_LOOK, SC_VICT, SC_REL} t_scan;

    t_state          r_state;
    t_scan           r_smode;
    t_in_item        r_in;
    t_out_item       r_pend;
    t_out_item       r_out;
    logic            r_ovld;
    logic            r_replace_mode;
    logic [4:0]      r_frame_limit;
    logic [FRAMES-1:0] r_in_list;
    logic [FRAMES-1:0] r_pinned;
    logic [FRAMES-1:0] r_modified;
    logic [IW-1:0]   r_rank_a [FRAMES];
    logic [CW-1:0]   r_free_depth;
    logic [CW-1:0]   r_taken;
    logic [31:0]     r_stat [4];
    logic [IW-1:0]   r_sidx;
    logic [IW-1:0]   r_cidx;
    logic            r_iss;
    logic            r_cvld;
    logic            r_hit;
    logic [IW-1:0]   r_f;
    logic [IW-1:0]   r_rank;
    logic            r_pin;
    logic            r_mod;
    t_tag            r_ctag;
    logic            r_wb;

    t_tag            w_tag_rd;
    logic [IW-1:0]   w_stk_rd;
    logic            w_tag_we;
    logic            w_stk_we;
    logic            w_lim_ok;
    logic [IW-1:0]   w_c_rank;
    logic            w_elig;
    logic            w_better;
    logic            w_match;
    t_tag            w_req_tag;

    // Tag store, read at the scan index
    pbpm_ram #(.WIDTH(TAG_W), .DEPTH(FRAMES)) u_tag_ram (
        .i_clk  (i_clk),
        .i_we   (w_tag_we),
        .i_waddr(r_f),
        .i_wdata(w_req_tag),
        .i_raddr(r_sidx),
        .o_rdata(w_tag_rd)
    );

    // Free frame stack, read at its top
    pbpm_ram #(.WIDTH(IW), .DEPTH(FRAMES)) u_stk_ram (
        .i_clk  (i_clk),
        .i_we   (w_stk_we),
        .i_waddr(IW'(r_free_depth)),
        .i_wdata(r_f),
        .i_raddr(IW'(r_free_depth - CW'(1))),
        .o_rdata(w_stk_rd)
    );

    assign w_req_tag = '{file_id: r_in.file_id, page_num: r_in.page_num};
    assign w_tag_we  = (r_state == S_FILL);
    assign w_stk_we  = (r_state == S_RDEC) && r_hit && !r_pin &&
                       (r_free_depth < CW'(FRAMES));
    assign w_lim_ok  = (LW'(r_taken) < LW'(r_frame_limit)) && (r_taken < CW'(FRAMES));

    // Shared compare unit of the scan
    assign w_c_rank = r_rank_a[r_cidx];
    assign w_match  = r_in_list[r_cidx] && (w_tag_rd == w_req_tag);
    always_comb begin
        w_elig   = 1'b0;
        w_better = 1'b0;
        case (r_smode)
            SC_VICT: begin
                w_elig   = r_in_list[r_cidx] && !r_pinned[r_cidx];
                w_better = !r_hit || (r_replace_mode ? (w_c_rank < r_rank)
                                                     : (w_c_rank > r_rank));
            end
            SC_REL: begin
                w_elig   = r_in_list[r_cidx] && (w_tag_rd.file_id == r_in.file_id);
                w_better = !r_hit || (w_c_rank < r_rank);
            end
            default: begin
                w_elig   = w_match;
                w_better = 1'b1;
            end
        endcase
    end

    // Sequencer, frame state and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_smode        <= SC_LOOK;
            r_ovld         <= 1'b0;
            r_replace_mode <= 1'b0;
            r_frame_limit  <= 5'd16;
            r_in_list      <= '0;
            r_pinned       <= '0;
            r_modified     <= '0;
            r_free_depth   <= '0;
            r_taken        <= '0;
            r_iss          <= 1'b0;
            r_cvld         <= 1'b0;
            r_hit          <= 1'b0;
            r_wb           <= 1'b0;
            for (int i = 0; i < 4; i++) begin
                r_stat[i] <= '0;
            end
        end else begin
            // Take configuration writes
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_REPLACE_MODE: r_replace_mode <= i_cfg_data[0];
                    CFG_FRAME_LIMIT:  r_frame_limit  <= i_cfg_data;
                    default: ;
                endcase
            end
            // Drop the result once taken
            if (r_ovld && i_out_ready) begin
                r_ovld <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_in   <= i_in_item;
                        r_sidx <= '0;
                        r_iss  <= 1'b1;
                        r_cvld <= 1'b0;
                        r_hit  <= 1'b0;
                        r_wb   <= 1'b0;
                        unique case (i_in_item.cmd) inside
                            CMD_GET: begin
                                r_stat[0] <= r_stat[0] + 32'd1;
                                r_smode   <= SC_LOOK;
                                r_state   <= S_SCAN;
                            end
                            CMD_UNFIX, CMD_MARK, CMD_ALLOC: begin
                                r_smode <= SC_LOOK;
                                r_state <= S_SCAN;
                            end
                            CMD_RELEASE: begin
                                r_smode <= SC_REL;
                                r_state <= S_SCAN;
                            end
                            default: begin
                                r_pend        <= '0;
                                r_pend.status <= ST_OK;
                                r_pend.last   <= 1'b1;
                                r_state       <= S_EMIT;
                            end
                        endcase
                    end
                end
                S_SCAN: begin
                    // Advance the read index
                    if (r_iss) begin
                        r_cidx <= r_sidx;
                        r_cvld <= 1'b1;
                        if (r_sidx == LAST_IDX) begin
                            r_iss <= 1'b0;
                        end else begin
                            r_sidx <= r_sidx + IW'(1);
                        end
                    end else begin
                        r_cvld <= 1'b0;
                    end
                    // Compare the entry read last cycle
                    if (r_cvld) begin
                        if (w_elig && w_better) begin
                            r_hit  <= 1'b1;
                            r_f    <= r_cidx;
                            r_rank <= w_c_rank;
                            r_pin  <= r_pinned[r_cidx];
                            r_mod  <= r_modified[r_cidx];
                            r_ctag <= w_tag_rd;
                        end
                        if ((r_smode == SC_LOOK && w_match) || r_cidx == LAST_IDX) begin
                            case (r_smode)
                                SC_VICT: r_state <= S_VDEC;
                                SC_REL:  r_state <= S_RDEC;
                                default: r_state <= S_DEC;
                            endcase
                        end
                    end
                end
                S_DEC: begin
                    r_pend <= '0;
                    r_pend.last <= 1'b1;
                    r_state <= S_EMIT;
                    unique case (r_in.cmd) inside
                        CMD_UNFIX, CMD_MARK: begin
                            if (!r_hit) begin
                                r_pend.status <= ST_NOTIN;
                            end else if (!r_pin) begin
                                r_pend.status <= ST_UNFIXED;
                                r_pend.frame  <= 4'(r_f);
                            end else begin
                                if (r_in.cmd == CMD_UNFIX) begin
                                    if (r_in.mark_dirty) begin
                                        r_modified[r_f] <= 1'b1;
                                        r_stat[2]       <= r_stat[2] + 32'd1;
                                    end
                                    r_pinned[r_f] <= 1'b0;
                                end else begin
                                    r_modified[r_f] <= 1'b1;
                                end
                                // Move the frame to the head of the recency order
                                for (int i = 0; i < FRAMES; i++) begin
                                    if (r_in_list[i] && r_rank_a[i] < r_rank) begin
                                        r_rank_a[i] <= r_rank_a[i] + IW'(1);
                                    end
                                end
                                r_rank_a[r_f] <= '0;
                                r_pend.status <= ST_OK;
                                r_pend.frame  <= 4'(r_f);
                            end
                        end
                        default: begin
                            if (r_hit && r_in.cmd == CMD_ALLOC) begin
                                r_pend.status <= ST_ALREADY;
                            end else if (r_hit) begin
                                r_pend.frame <= 4'(r_f);
                                if (r_pin) begin
                                    r_pend.status <= ST_FIXED;
                                end else begin
                                    r_pinned[r_f] <= 1'b1;
                                    r_pend.status <= ST_OK;
                                end
                            end else begin
                                // Miss: take a frame
                                if (r_in.cmd == CMD_GET) begin
                                    r_stat[1] <= r_stat[1] + 32'd1;
                                end
                                if (r_free_depth != '0) begin
                                    r_free_depth <= r_free_depth - CW'(1);
                                    r_state      <= S_POPD;
                                end else if (w_lim_ok) begin
                                    r_f     <= IW'(r_taken);
                                    r_taken <= r_taken + CW'(1);
                                    for (int i = 0; i < FRAMES; i++) begin
                                        if (r_in_list[i]) begin
                                            r_rank_a[i] <= r_rank_a[i] + IW'(1);
                                        end
                                    end
                                    r_rank_a[IW'(r_taken)]  <= '0;
                                    r_in_list[IW'(r_taken)] <= 1'b1;
                                    r_state <= S_FILL;
                                end else begin
                                    r_sidx  <= '0;
                                    r_iss   <= 1'b1;
                                    r_cvld  <= 1'b0;
                                    r_hit   <= 1'b0;
                                    r_smode <= SC_VICT;
                                    r_state <= S_SCAN;
                                end
                            end
                        end
                    endcase
                end
                S_POPD: begin
                    // Link the popped frame at the head
                    r_f <= w_stk_rd;
                    for (int i = 0; i < FRAMES; i++) begin
                        if (r_in_list[i]) begin
                            r_rank_a[i] <= r_rank_a[i] + IW'(1);
                        end
                    end
                    r_rank_a[w_stk_rd]  <= '0;
                    r_in_list[w_stk_rd] <= 1'b1;
                    r_state <= S_FILL;
                end
                S_VDEC: begin
                    if (!r_hit) begin
                        r_pend        <= '0;
                        r_pend.status <= ST_NOBUF;
                        r_pend.last   <= 1'b1;
                        r_state       <= S_EMIT;
                    end else begin
                        if (r_mod) begin
                            r_wb      <= 1'b1;
                            r_stat[3] <= r_stat[3] + 32'd1;
                        end
                        r_modified[r_f] <= 1'b0;
                        for (int i = 0; i < FRAMES; i++) begin
                            if (r_in_list[i] && r_rank_a[i] < r_rank) begin
                                r_rank_a[i] <= r_rank_a[i] + IW'(1);
                            end
                        end
                        r_rank_a[r_f] <= '0;
                        r_state <= S_FILL;
                    end
                end
                S_FILL: begin
                    r_pinned[r_f]    <= 1'b1;
                    r_modified[r_f]  <= 1'b0;
                    r_pend           <= '0;
                    r_pend.status    <= ST_OK;
                    r_pend.frame     <= 4'(r_f);
                    r_pend.fetch     <= (r_in.cmd == CMD_GET);
                    r_pend.writeback <= r_wb;
                    r_pend.wb_file   <= r_wb ? r_ctag.file_id : 8'd0;
                    r_pend.wb_page   <= r_wb ? r_ctag.page_num : 31'd0;
                    r_pend.last      <= 1'b1;
                    r_state          <= S_EMIT;
                end
                S_RDEC: begin
                    r_pend <= '0;
                    if (!r_hit || r_pin) begin
                        r_pend.status <= r_hit ? ST_FIXED : ST_OK;
                        r_pend.last   <= 1'b1;
                        r_state       <= S_EMIT;
                    end else begin
                        // Release the frame and push it on the free stack
                        r_in_list[r_f]  <= 1'b0;
                        r_modified[r_f] <= 1'b0;
                        for (int i = 0; i < FRAMES; i++) begin
                            if (r_in_list[i] && r_rank_a[i] > r_rank) begin
                                r_rank_a[i] <= r_rank_a[i] - IW'(1);
                            end
                        end
                        if (r_free_depth < CW'(FRAMES)) begin
                            r_free_depth <= r_free_depth + CW'(1);
                        end
                        r_sidx <= '0;
                        r_iss  <= 1'b1;
                        r_cvld <= 1'b0;
                        r_hit  <= 1'b0;
                        if (r_mod) begin
                            r_stat[3]        <= r_stat[3] + 32'd1;
                            r_pend.status    <= ST_OK;
                            r_pend.frame     <= 4'(r_f);
                            r_pend.writeback <= 1'b1;
                            r_pend.wb_file   <= r_ctag.file_id;
                            r_pend.wb_page   <= r_ctag.page_num;
                            r_pend.last      <= 1'b0;
                            r_state          <= S_EMIT;
                        end else begin
                            r_state <= S_SCAN;
                        end
                    end
                end
                S_EMIT: begin
                    // Hold until the result register is free
                    if (!r_ovld || i_out_ready) begin
                        r_ovld <= 1'b1;
                        r_out  <= r_pend;
                        r_out.logical_reads   <= r_stat[0];
                        r_out.physical_reads  <= r_stat[1];
                        r_out.logical_writes  <= r_stat[2];
                        r_out.physical_writes <= r_stat[3];
                        r_state <= r_pend.last ? S_IDLE : S_SCAN;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_ovld;
    assign o_out_item  = r_out;
    assign o_cfg_ready = 1'b1;

    // Frame bookkeeping invariants and result hold
    `PBPM_ASSERT_IMP(a_free_le_taken, i_clk, i_rst_n, 1'b1, r_free_depth <= r_taken)
    `PBPM_ASSERT_IMP(a_taken_le_frames, i_clk, i_rst_n, 1'b1, r_taken <= CW'(FRAMES))
    `PBPM_ASSERT_IMP(a_listed_le_taken, i_clk, i_rst_n, 1'b1, $countones(r_in_list) <= r_taken)
    `PBPM_ASSERT_NXT(a_emit_holds, i_clk, i_rst_n, r_state == S_EMIT && r_ovld && !i_out_ready, r_state == S_EMIT)

endmodule

// ----- tb/sv/pbpm_checker.sv -----
// Checker for the page buffer pool manager: watches the channels, predicts the results and compares.
module pbpm_checker
    import pbpm_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  t_in_item    i_in_item,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  t_out_item   i_out_item,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [4:0]  i_cfg_data,
    output int          o_fail_count,
    output int          o_pending
);

    localparam int NF = 16;

    // Shadow copy of the pool
    logic [7:0]  pool_file [NF];
    logic [30:0] pool_page [NF];
    logic        pool_listed [NF];
    logic        pool_fixed [NF];
    logic        pool_dirty [NF];
    int unsigned pool_rank [NF];
    int unsigned spare_stack [NF];
    int unsigned spare_depth;
    int unsigned fresh_used;
    logic [31:0] stats [4];
    logic        mru_mode;
    logic [4:0]  limit_reg;

    t_out_item   expected_results [$];
    int          fail_count;

    assign o_fail_count = fail_count;
    assign o_pending    = expected_results.size();

    function automatic int lookup_frame(logic [7:0] f, logic [30:0] p);
        for (int i = 0; i < NF; i++)
            if (pool_listed[i] && pool_file[i] == f && pool_page[i] == p) return i;
        return -1;
    endfunction

    function automatic void move_to_head(int f);
        for (int i = 0; i < NF; i++)
            if (pool_listed[i]) pool_rank[i]++;
        pool_rank[f]   = 0;
        pool_listed[f] = 1'b1;
    endfunction

    function automatic void drop_from_list(int f);
        int unsigned r;
        r = pool_rank[f];
        pool_listed[f] = 1'b0;
        for (int i = 0; i < NF; i++)
            if (pool_listed[i] && pool_rank[i] > r) pool_rank[i]--;
    endfunction

    function automatic void push_result(logic [2:0] st, int fr, logic fe, logic wb,
                                        logic [7:0] wf, logic [30:0] wp, logic lst);
        t_out_item r;
        r.status = st;
        r.frame = fr[3:0];
        r.fetch = fe;
        r.writeback = wb;
        r.wb_file = wf;
        r.wb_page = wp;
        r.last = lst;
        r.logical_reads = stats[0];
        r.physical_reads = stats[1];
        r.logical_writes = stats[2];
        r.physical_writes = stats[3];
        expected_results.push_back(r);
    endfunction

    // Pick a frame: spare stack, fresh frame, then victim
    function automatic int claim_frame(output logic wb, output logic [7:0] wf,
                                       output logic [30:0] wp);
        int unsigned lim;
        int f;
        lim = (limit_reg < NF) ? limit_reg : NF;
        f = -1;
        wb = 0;
        wf = '0;
        wp = '0;
        if (spare_depth > 0) begin
            spare_depth--;
            f = spare_stack[spare_depth] % NF;
        end else if (fresh_used < lim) begin
            f = fresh_used;
            fresh_used++;
        end else begin
            for (int i = 0; i < NF; i++) begin
                if (!pool_listed[i] || pool_fixed[i]) continue;
                if (f < 0 || (!mru_mode && pool_rank[i] > pool_rank[f])
                    || (mru_mode && pool_rank[i] < pool_rank[f])) f = i;
            end
            if (f < 0) return -1;
            if (pool_dirty[f]) begin
                wb = 1;
                wf = pool_file[f];
                wp = pool_page[f];
                stats[3]++;
            end
            pool_dirty[f] = 0;
            drop_from_list(f);
        end
        move_to_head(f);
        return f;
    endfunction

    function automatic void predict_item(t_in_item it);
        int f;
        int n;
        int order [NF];
        logic wb;
        logic [7:0] wf;
        logic [30:0] wp;
        case (it.cmd)
            CMD_GET, CMD_ALLOC: begin
                if (it.cmd == CMD_GET) stats[0]++;
                f = lookup_frame(it.file_id, it.page_num);
                if (f >= 0 && it.cmd == CMD_ALLOC) begin
                    push_result(ST_ALREADY, 0, 0, 0, 0, 0, 1);
                end else if (f >= 0) begin
                    if (pool_fixed[f]) push_result(ST_FIXED, f, 0, 0, 0, 0, 1);
                    else begin
                        pool_fixed[f] = 1;
                        push_result(ST_OK, f, 0, 0, 0, 0, 1);
                    end
                end else begin
                    if (it.cmd == CMD_GET) stats[1]++;
                    f = claim_frame(wb, wf, wp);
                    if (f < 0) push_result(ST_NOBUF, 0, 0, 0, 0, 0, 1);
                    else begin
                        pool_file[f] = it.file_id;
                        pool_page[f] = it.page_num;
                        pool_dirty[f] = 0;
                        pool_fixed[f] = 1;
                        push_result(ST_OK, f, it.cmd == CMD_GET, wb, wf, wp, 1);
                    end
                end
            end
            CMD_UNFIX, CMD_MARK: begin
                f = lookup_frame(it.file_id, it.page_num);
                if (f < 0) push_result(ST_NOTIN, 0, 0, 0, 0, 0, 1);
                else if (!pool_fixed[f]) push_result(ST_UNFIXED, f, 0, 0, 0, 0, 1);
                else begin
                    if (it.cmd == CMD_UNFIX) begin
                        if (it.mark_dirty) begin
                            pool_dirty[f] = 1;
                            stats[2]++;
                        end
                        pool_fixed[f] = 0;
                    end else begin
                        pool_dirty[f] = 1;
                    end
                    drop_from_list(f);
                    move_to_head(f);
                    push_result(ST_OK, f, 0, 0, 0, 0, 1);
                end
            end
            CMD_RELEASE: begin
                n = 0;
                for (int r = 0; r < NF; r++)
                    for (int i = 0; i < NF; i++)
                        if (pool_listed[i] && pool_rank[i] == r) begin
                            order[n] = i;
                            n++;
                        end
                for (int i = 0; i < n; i++) begin
                    f = order[i];
                    if (pool_file[f] != it.file_id) continue;
                    if (pool_fixed[f]) begin
                        push_result(ST_FIXED, 0, 0, 0, 0, 0, 1);
                        return;
                    end
                    if (pool_dirty[f]) begin
                        stats[3]++;
                        push_result(ST_OK, f, 0, 1, pool_file[f], pool_page[f], 0);
                    end
                    pool_dirty[f] = 0;
                    drop_from_list(f);
                    if (spare_depth < NF) begin
                        spare_stack[spare_depth] = f;
                        spare_depth++;
                    end
                end
                push_result(ST_OK, 0, 0, 0, 0, 0, 1);
            end
            default: push_result(ST_OK, 0, 0, 0, 0, 0, 1);
        endcase
    endfunction

    function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s: expected %0d, got %0d", name, exp_v, act_v);
            fail_count++;
        end
    endfunction

    // Predict on accepted items, compare on accepted results
    always @(posedge i_clk) begin
        t_out_item e;
        t_out_item a;
        if (!i_rst_n) begin
            for (int i = 0; i < NF; i++) begin
                pool_listed[i] = 0;
                pool_fixed[i] = 0;
                pool_dirty[i] = 0;
                pool_rank[i] = 0;
                pool_file[i] = '0;
                pool_page[i] = '0;
                spare_stack[i] = 0;
            end
            spare_depth = 0;
            fresh_used = 0;
            for (int i = 0; i < 4; i++) stats[i] = '0;
            mru_mode = 0;
            limit_reg = 5'd16;
            expected_results.delete();
            fail_count = 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == CFG_REPLACE_MODE) mru_mode = i_cfg_data[0];
                else if (i_cfg_index == CFG_FRAME_LIMIT) limit_reg = i_cfg_data;
            end
            if (i_out_valid && i_out_ready) begin
                a = i_out_item;
                if (expected_results.size() == 0) begin
                    $error("result with no expectation waiting");
                    fail_count++;
                end else begin
                    e = expected_results.pop_front();
                    check_field("status", e.status, a.status);
                    check_field("frame", e.frame, a.frame);
                    check_field("fetch", e.fetch, a.fetch);
                    check_field("writeback", e.writeback, a.writeback);
                    check_field("wb_file", e.wb_file, a.wb_file);
                    check_field("wb_page", e.wb_page, a.wb_page);
                    check_field("last", e.last, a.last);
                    check_field("logical_reads", e.logical_reads, a.logical_reads);
                    check_field("physical_reads", e.physical_reads, a.physical_reads);
                    check_field("logical_writes", e.logical_writes, a.logical_writes);
                    check_field("physical_writes", e.physical_writes, a.physical_writes);
                end
            end
            if (i_in_valid && i_in_ready) predict_item(i_in_item);
        end
    end

endmodule

// ----- tb/sv/testbench.sv -----
// Top of the page buffer pool manager testbench: clock, reset, stimulus and verdict.
module testbench;
    import pbpm_pkg::*;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    t_in_item   in_item;
    logic       out_valid;
    logic       out_ready;
    t_out_item  out_item;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [1:0] cfg_index;
    logic [4:0] cfg_data;
    int         fail_count;
    int         pending;
    int         cycle_count;
    logic       quiet_phase;
    logic       hold_off_req;
    logic       hold_off_done;

    page_buffer_pool_manager_core DUT (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (in_ready),
        .i_in_item  (in_item),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_out_item (out_item),
        .i_cfg_valid(cfg_valid),
        .o_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index),
        .i_cfg_data (cfg_data)
    );

    pbpm_checker checker_inst (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_ready  (in_ready),
        .i_in_item   (in_item),
        .i_out_valid (out_valid),
        .i_out_ready (out_ready),
        .i_out_item  (out_item),
        .i_cfg_valid (cfg_valid),
        .i_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    // Clock
    initial clk = 0;
    always begin
        #1 clk = 1;
        #1 clk = 0;
    end

    // Stop a hung run
    initial cycle_count = 0;
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 1000000) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Receiver: random stall bursts, one long hold-off on request
    initial begin
        int gap;
        out_ready = 0;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever begin
            if (hold_off_req && !hold_off_done) begin
                out_ready <= 0;
                repeat (600) @(posedge clk);
                hold_off_done <= 1;
            end else if (!quiet_phase && $urandom_range(0, 3) == 0) begin
                gap = $urandom_range(1, 15);
                out_ready <= 0;
                repeat (gap) @(posedge clk);
            end else begin
                out_ready <= 1;
                repeat ($urandom_range(1, 20)) @(posedge clk);
            end
        end
    end

    // Offer one item and wait for its acceptance; valid stays up for the next item
    task automatic send_item(logic [2:0] c, logic [7:0] f, logic [30:0] p, logic d);
        if (!quiet_phase && $urandom_range(0, 4) == 0) begin
            in_valid <= 0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
        in_valid <= 1;
        in_item  <= '{cmd: c, file_id: f, page_num: p, mark_dirty: d};
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    // Wait until every expected result is back and the block has settled
    task automatic drain_pool();
        in_valid <= 0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (150) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [4:0] val);
        cfg_valid <= 1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 0;
        @(posedge clk);
    endtask

    // Random item biased toward a small set of tags so hits and victims happen
    task automatic send_random_item();
        logic [2:0] c;
        logic [7:0] f;
        logic [30:0] p;
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 40) c = CMD_GET;
        else if (sel < 65) c = CMD_UNFIX;
        else if (sel < 75) c = CMD_MARK;
        else if (sel < 85) c = CMD_ALLOC;
        else if (sel < 95) c = CMD_RELEASE;
        else c = 3'($urandom_range(5, 7));
        if ($urandom_range(0, 9) == 0) begin
            f = 8'($urandom);
            p = 31'($urandom);
        end else begin
            f = 8'($urandom_range(0, 2)) ^ {8{$urandom_range(0, 5) == 0}};
            p = 31'($urandom_range(0, 11)) ^ {31{$urandom_range(0, 7) == 0}};
        end
        send_item(c, f, p, 1'($urandom));
    endtask

    initial begin
        int limits [5];
        limits = '{16, 1, 4, 0, 31};
        rst_n = 0;
        in_valid = 0;
        in_item = '0;
        cfg_valid = 0;
        cfg_index = '0;
        cfg_data = '0;
        quiet_phase = 0;
        hold_off_req = 0;
        hold_off_done = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // Directed: extremes, every command, special cases
        send_item(CMD_UNFIX, 8'hFF, 31'h7FFFFFFF, 1);
        send_item(CMD_GET, 8'hFF, 31'h7FFFFFFF, 0);
        send_item(CMD_GET, 8'hFF, 31'h7FFFFFFF, 0);
        send_item(CMD_MARK, 8'hFF, 31'h7FFFFFFF, 0);
        send_item(CMD_UNFIX, 8'hFF, 31'h7FFFFFFF, 1);
        send_item(CMD_UNFIX, 8'hFF, 31'h7FFFFFFF, 0);
        send_item(CMD_GET, 8'hFF, 31'h7FFFFFFF, 1);
        send_item(CMD_ALLOC, 8'h00, 31'h0, 0);
        send_item(CMD_ALLOC, 8'h00, 31'h0, 0);
        send_item(CMD_UNFIX, 8'h00, 31'h0, 1);
        send_item(CMD_RELEASE, 8'hFF, 31'h0, 0);
        send_item(CMD_UNFIX, 8'hFF, 31'h7FFFFFFF, 1);
        send_item(CMD_RELEASE, 8'hFF, 31'h0, 0);
        send_item(CMD_RELEASE, 8'h00, 31'h0, 0);
        send_item(3'd5, 8'h12, 31'h345, 1);
        send_item(3'd7, 8'h00, 31'h0, 0);
        drain_pool();

        // Small limit: no victim, then victim with writeback
        write_reg(CFG_FRAME_LIMIT, 5'd1);
        write_reg(CFG_REPLACE_MODE, 1'b1);
        send_item(CMD_GET, 8'd1, 31'd1, 0);
        send_item(CMD_GET, 8'd1, 31'd2, 0);
        send_item(CMD_UNFIX, 8'd1, 31'd1, 1);
        send_item(CMD_GET, 8'd1, 31'd2, 0);
        send_item(CMD_UNFIX, 8'd1, 31'd2, 1);
        send_item(CMD_RELEASE, 8'd1, 31'd0, 0);
        drain_pool();

        // Random phases over several settings
        for (int ph = 0; ph < 5; ph++) begin
            write_reg(CFG_FRAME_LIMIT, 5'(limits[ph]));
            write_reg(CFG_REPLACE_MODE, 1'(ph));
            if (ph == 4) quiet_phase <= 1;
            if (ph == 1) hold_off_req <= 1;
            for (int n = 0; n < 22; n++) send_random_item();
            drain_pool();
        end

        if (fail_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+design
design/pbpm_pkg.sv
design/pbpm_ram.sv
design/page_buffer_pool_manager_core.sv
tb/sv/pbpm_checker.sv
tb/sv/testbench.sv
